FILE: src/sobel_edge_magnitude_rgb_macros.svh
// Assertion macros used by the checker file.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH
// Property holds as an implication each clock unless in reset.
`define SEM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Property holds on the next cycle.
`define SEM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: src/sem_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared types and constants for the RGB Sobel block.
// ----------------------------------------------------------------------------
package sem_pkg;
    localparam int unsigned PIX_W = 24;
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;
    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;
    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;

    typedef logic [PIX_W-1:0] t_pix;

    // Row and column validity flags and the end-of-frame flag for one output position.
    typedef struct packed {
        logic top_ok;
        logic row_ok;
        logic bot_ok;
        logic left_ok;
        logic col_ok;
        logic right_ok;
        logic eof;
    } t_edge;
endpackage

FILE: src/sem_line_mem.sv
// ----------------------------------------------------------------------------
// Sobel line memory
// Two-line store with a registered read. The write-back of a column lands
// in the cycle after its read, and a read of that same column is forwarded.
// ----------------------------------------------------------------------------
module sem_line_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [AW-1:0] i_addr,
    input  sem_pkg::t_pix i_new_mid,
    output sem_pkg::t_pix o_top,
    output sem_pkg::t_pix o_mid
);
    // Each entry packs the upper and middle line pixel of one column.
    logic [2*sem_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [2*sem_pkg::PIX_W-1:0] r_rd;
    logic                        r_wr_pend;
    logic [AW-1:0]               r_wr_addr;
    sem_pkg::t_pix               r_wr_mid;
    logic [2*sem_pkg::PIX_W-1:0] w_wr_data;

    // The old middle pixel moves up and the new pixel becomes the middle.
    assign w_wr_data = {r_rd[sem_pkg::PIX_W-1:0], r_wr_mid};

    // A write-back is pending in the cycle after each access.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= i_en;
        end
    end

    // Capture the column and new pixel of the access.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wr_addr <= i_addr;
            r_wr_mid  <= i_new_mid;
        end
    end

    // Registered read with forwarding of the pending write-back.
    always_ff @(posedge i_clk) begin
        if (r_wr_pend) begin
            r_mem[r_wr_addr] <= w_wr_data;
        end
        if (i_en) begin
            if (r_wr_pend && r_wr_addr == i_addr) begin
                r_rd <= w_wr_data;
            end else begin
                r_rd <= r_mem[i_addr];
            end
        end
    end

    assign o_top = r_rd[2*sem_pkg::PIX_W-1:sem_pkg::PIX_W];
    assign o_mid = r_rd[sem_pkg::PIX_W-1:0];
endmodule

FILE: src/sem_mag.sv
// ----------------------------------------------------------------------------
// Sobel magnitude pipeline
// Computes gradients, sums squares, and takes a rounded square root over
// eight pipelined steps per channel.
// ----------------------------------------------------------------------------
module sem_mag (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_vld,
    input  sem_pkg::t_pix i_w [9],
    input  sem_pkg::t_edge i_edge,
    output logic          o_vld,
    output logic [7:0]    o_mag [3],
    output logic          o_eof
);
    localparam int unsigned NST = 8;

    logic signed [11:0] w_gx [3];
    logic signed [11:0] w_gy [3];
    logic [7:0]  w_p [9][3];
    logic        w_ok [9];

    logic [20:0] r_s   [3];
    logic        r_v0;
    logic        r_e0;
    logic [20:0] r_ss  [NST][3];
    logic [7:0]  r_q   [NST][3];
    logic        r_sv  [NST];
    logic        r_se  [NST];

    // Masked window taps and the two Sobel kernels.
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            w_ok[i] = ((i / 3 != 0) || i_edge.top_ok) && ((i / 3 != 1) || i_edge.row_ok)
                && ((i / 3 != 2) || i_edge.bot_ok) && ((i % 3 != 0) || i_edge.left_ok)
                && ((i % 3 != 1) || i_edge.col_ok) && ((i % 3 != 2) || i_edge.right_ok);
            for (int k = 0; k < 3; k++) begin
                w_p[i][k] = w_ok[i] ? i_w[i][16-8*k +: 8] : 8'd0;
            end
        end
        for (int k = 0; k < 3; k++) begin
            w_gx[k] = $signed({4'd0, w_p[2][k]}) - $signed({4'd0, w_p[0][k]})
                + 12'sd2 * ($signed({4'd0, w_p[5][k]}) - $signed({4'd0, w_p[3][k]}))
                + $signed({4'd0, w_p[8][k]}) - $signed({4'd0, w_p[6][k]});
            w_gy[k] = $signed({4'd0, w_p[6][k]}) - $signed({4'd0, w_p[0][k]})
                + 12'sd2 * ($signed({4'd0, w_p[7][k]}) - $signed({4'd0, w_p[1][k]}))
                + $signed({4'd0, w_p[8][k]}) - $signed({4'd0, w_p[2][k]});
        end
    end

    // Sum of squares stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_adv) begin
            r_v0 <= i_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_e0 <= i_edge.eof;
            for (int k = 0; k < 3; k++) begin
                r_s[k] <= 21'(22'(w_gx[k]) * 22'(w_gx[k]) + 22'(w_gy[k]) * 22'(w_gy[k]));
            end
        end
    end

    // One result bit per stage: keep q|bit when t*t - t + 1 <= s.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NST; j++) r_sv[j] <= 1'b0;
        end else if (i_adv) begin
            r_sv[0] <= r_v0;
            for (int j = 1; j < NST; j++) r_sv[j] <= r_sv[j-1];
        end
    end
    always_ff @(posedge i_clk) begin
        logic [7:0]  t;
        logic [16:0] sq;
        if (i_adv) begin
            r_se[0] <= r_e0;
            for (int j = 1; j < NST; j++) r_se[j] <= r_se[j-1];
            for (int k = 0; k < 3; k++) begin
                t = 8'h80;
                sq = 17'(t) * 17'(t) - 17'(t) + 17'd1;
                r_ss[0][k] <= r_s[k];
                r_q[0][k]  <= (21'(sq) <= r_s[k]) ? t : 8'd0;
                for (int j = 1; j < NST; j++) begin
                    t = r_q[j-1][k] | (8'h80 >> j);
                    sq = 17'(t) * 17'(t) - 17'(t) + 17'd1;
                    r_ss[j][k] <= r_ss[j-1][k];
                    r_q[j][k]  <= (21'(sq) <= r_ss[j-1][k]) ? t : r_q[j-1][k];
                end
            end
        end
    end

    assign o_vld = r_sv[NST-1];
    assign o_eof = r_se[NST-1];
    always_comb begin
        for (int k = 0; k < 3; k++) o_mag[k] = r_q[NST-1][k];
    end
endmodule

FILE: src/sobel_edge_magnitude_rgb.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude, RGB
// Streaming 3x3 Sobel magnitude per channel with two line stores in memory.
// ----------------------------------------------------------------------------
// Channel | Signals                                 | Direction
// in      | i_valid/o_ready, i_cmd, i_in_*           | input
// out     | o_valid/i_ready, o_out_*, o_end_of_frame | output
// cfg     | i_cfg_we, i_cfg_index, i_cfg_data        | input
// One pixel per cycle when the output is free; the path runs through
// the line-memory read, window shift, square sum and eight root steps.
// The whole pipeline advances only when its last stage is empty or taken.
// Reset is synchronous, active low, and clears counters and window.
// Line memory contents are undefined until written; no clearing pass.
module sobel_edge_magnitude_rgb #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_in_red,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_blue,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic        o_end_of_frame,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned CW = 14;

    logic [10:0] r_width;
    logic [12:0] r_height;
    logic [CW-1:0] w_w, w_h;
    logic [CW-1:0] r_ic, r_ir, r_oc, r_or;
    logic w_adv, w_acc, w_emit, w_eof;
    sem_pkg::t_pix w_v, w_top, w_mid;
    sem_pkg::t_pix r_win [9];
    sem_pkg::t_pix r_v1;
    logic r_e1;
    sem_pkg::t_edge r_edge1;
    sem_pkg::t_edge w_edge;
    logic [AW-1:0] w_addr;
    logic [7:0] w_mag [3];
    logic w_mvld, w_meof;

    // Effective frame size.
    always_comb begin
        w_w = (r_width == 11'd0) ? CW'(1) : (32'(r_width) > MAX_WIDTH)
            ? CW'(MAX_WIDTH) : CW'(r_width);
        w_h = (r_height == 13'd0) ? CW'(1) : (32'(r_height) > MAX_HEIGHT)
            ? CW'(MAX_HEIGHT) : CW'(r_height);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sem_pkg::WIDTH_RESET;
            r_height <= sem_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == sem_pkg::REG_FRAME_WIDTH) r_width <= i_cfg_data[10:0];
            else r_height <= i_cfg_data;
        end
    end

    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;
    assign w_acc   = i_valid && w_adv;
    assign w_v     = (i_cmd == sem_pkg::CMD_PIXEL && r_ir < w_h)
        ? {i_in_red, i_in_green, i_in_blue} : '0;
    assign w_addr  = (r_ic < CW'(MAX_WIDTH)) ? r_ic[AW-1:0] : '0;
    assign w_emit  = (r_ir >= CW'(2)) || (r_ir == CW'(1) && r_ic >= CW'(1));
    assign w_eof   = (r_or + CW'(1) >= w_h) && (r_oc + CW'(1) >= w_w);
    assign w_edge  = '{top_ok: (r_or != '0) && (r_or <= w_h), row_ok: r_or < w_h,
        bot_ok: r_or + CW'(1) < w_h, left_ok: (r_oc != '0) && (r_oc <= w_w),
        col_ok: r_oc < w_w, right_ok: r_oc + CW'(1) < w_w, eof: w_eof};

    sem_line_mem #(.DEPTH(MAX_WIDTH), .AW(AW)) u_mem (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_acc), .i_addr(w_addr),
        .i_new_mid(w_v), .o_top(w_top), .o_mid(w_mid)
    );

    // Position counters; output position follows emitted results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic <= '0; r_ir <= '0; r_oc <= '0; r_or <= '0; r_e1 <= 1'b0;
        end else if (w_adv) begin
            r_e1 <= w_acc && w_emit;
            if (w_acc) begin
                if (w_emit && w_eof) begin
                    r_ic <= '0; r_ir <= '0; r_oc <= '0; r_or <= '0;
                end else begin
                    if (r_ic + CW'(1) >= w_w) begin
                        r_ic <= '0;
                        if (r_ir < CW'(13'h1FFF)) r_ir <= r_ir + CW'(1);
                    end else begin
                        r_ic <= r_ic + CW'(1);
                    end
                    if (w_emit) begin
                        if (r_oc + CW'(1) >= w_w) begin
                            r_oc <= '0; r_or <= r_or + CW'(1);
                        end else begin
                            r_oc <= r_oc + CW'(1);
                        end
                    end
                end
            end
        end
    end

    // Window shift after the memory read returns.
    logic r_a1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1 <= 1'b0;
            for (int i = 0; i < 9; i++) r_win[i] <= '0;
        end else if (w_adv) begin
            r_a1 <= w_acc;
            if (r_a1) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r*3]   <= r_win[r*3+1];
                    r_win[r*3+1] <= r_win[r*3+2];
                end
                r_win[2] <= w_top;
                r_win[5] <= w_mid;
                r_win[8] <= r_v1;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_v1 <= w_v;
            r_edge1 <= w_edge;
        end
    end

    // Window stage: flags registered in step with the window shift.
    logic r_e2;
    sem_pkg::t_edge r_edge2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e2 <= 1'b0;
        else if (w_adv) r_e2 <= r_e1;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) r_edge2 <= r_edge1;
    end

    sem_mag u_mag (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_vld(r_e2), .i_w(r_win),
        .i_edge(r_edge2), .o_vld(w_mvld), .o_mag(w_mag), .o_eof(w_meof)
    );

    assign o_valid        = w_mvld;
    assign o_out_red      = w_mag[0];
    assign o_out_green    = w_mag[1];
    assign o_out_blue     = w_mag[2];
    assign o_end_of_frame = w_meof;
endmodule

FILE: src/sem_checker.sv
// ----------------------------------------------------------------------------
// Sobel port checker
// Watches the top-level ports for handshake and flow rules.
// ----------------------------------------------------------------------------
`include "sobel_edge_magnitude_rgb_macros.svh"
module sem_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_red,
    input logic       o_end_of_frame
);
    // A stalled result holds its data.
    `SEM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_out_red) && $stable(o_end_of_frame), "stalled result changed")
    // Input side opens whenever the output is free.
    `SEM_ASSERT_IMPL(a_ready_free, i_clk, i_rst_n, !o_valid, o_ready, "not ready while output empty")
    // Stalled output blocks input.
    `SEM_ASSERT_IMPL(a_ready_block, i_clk, i_rst_n, o_valid && !i_ready, !o_ready, "ready during output stall")
endmodule

bind sobel_edge_magnitude_rgb sem_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_out_red(o_out_red),
    .o_end_of_frame(o_end_of_frame)
);

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Streams whole RGB frames of assorted sizes through the block, including
// border, saturation and drain cases, while both handshakes stall at random.
// A built-in line-buffer model predicts every magnitude and end-of-frame flag.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_W = 1024;
    localparam int MAX_H = 4096;
    localparam int DRAIN_CYCLES = 30;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       eof;
    } t_mag;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_cmd = sem_pkg::CMD_PIXEL;
    logic [7:0]  i_in_red = '0;
    logic [7:0]  i_in_green = '0;
    logic [7:0]  i_in_blue = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_out_red;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_blue;
    logic        o_end_of_frame;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = sem_pkg::REG_FRAME_WIDTH;
    logic [12:0] i_cfg_data = '0;

    // Edge detector state as seen from outside.
    logic [23:0] upper_line [MAX_W];
    logic [23:0] middle_line [MAX_W];
    logic [23:0] window_pix [9];
    int          in_col, in_row, out_col, out_row;
    int          width_reg = sem_pkg::WIDTH_RESET;
    int          height_reg = sem_pkg::HEIGHT_RESET;

    t_mag        pending_mags [$];
    int          mismatch_count = 0;
    int          item_count = 0;
    int          stall_cycles = 0;
    bit          no_idle = 1'b0;

    sobel_edge_magnitude_rgb dut (.*);

    // Clock with a period of 12.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int clamp_size(int v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // Rounded square root, saturated at 255.
    function automatic logic [7:0] round_root(int unsigned s);
        int unsigned q;
        int unsigned t;
        q = 0;
        for (int unsigned b = 128; b != 0; b >>= 1) begin
            t = q | b;
            if (t * t - t + 1 <= s) q = t;
        end
        return q[7:0];
    endfunction

    // Advance the edge detector by one accepted item; queue any magnitude it yields.
    task automatic predict_edges(logic cmd, logic [23:0] rgb);
        int w, h, idx, y, x, kx, ky, p;
        int gx [3];
        int gy [3];
        logic [23:0] v, top, mid;
        bit emit;
        t_mag m;
        w = clamp_size(width_reg, MAX_W);
        h = clamp_size(height_reg, MAX_H);
        v = (cmd == sem_pkg::CMD_PIXEL && in_row < h) ? rgb : 24'd0;
        idx = (in_col < MAX_W) ? in_col : 0;
        top = upper_line[idx];
        mid = middle_line[idx];
        upper_line[idx] = mid;
        middle_line[idx] = v;
        for (int r = 0; r < 3; r++) begin
            window_pix[r*3] = window_pix[r*3+1];
            window_pix[r*3+1] = window_pix[r*3+2];
        end
        window_pix[2] = top;
        window_pix[5] = mid;
        window_pix[8] = v;
        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        if (in_col + 1 >= w) begin
            in_col = 0;
            if (in_row < 13'h1FFF) in_row++;
        end else begin
            in_col++;
        end
        if (!emit) return;

        // Convolve with the neighbors that lie inside the frame.
        for (int k = 0; k < 3; k++) begin
            gx[k] = 0;
            gy[k] = 0;
        end
        for (int r = 0; r < 3; r++) begin
            y = out_row + r - 1;
            if (y < 0 || y >= h) continue;
            for (int c = 0; c < 3; c++) begin
                x = out_col + c - 1;
                if (x < 0 || x >= w) continue;
                kx = (c - 1) * ((r == 1) ? 2 : 1);
                ky = (r - 1) * ((c == 1) ? 2 : 1);
                for (int k = 0; k < 3; k++) begin
                    p = (window_pix[r*3+c] >> (16 - 8 * k)) & 8'hFF;
                    gx[k] += p * kx;
                    gy[k] += p * ky;
                end
            end
        end
        m.red = round_root(gx[0] * gx[0] + gy[0] * gy[0]);
        m.green = round_root(gx[1] * gx[1] + gy[1] * gy[1]);
        m.blue = round_root(gx[2] * gx[2] + gy[2] * gy[2]);
        m.eof = (out_row + 1 >= h) && (out_col + 1 >= w);
        pending_mags.push_back(m);

        if (m.eof) begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        end else if (out_col + 1 >= w) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
    endtask

    // Send one transaction, idling now and then beforehand.
    task automatic send_item(logic cmd, logic [23:0] rgb);
        if (!no_idle && $urandom_range(99) < 12) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        {i_in_red, i_in_green, i_in_blue} <= rgb;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_edges(cmd, rgb);
        item_count++;
    endtask

    // Wait until every magnitude is back, then let the pipeline settle.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_mags.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic index, int value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value[12:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == sem_pkg::REG_FRAME_WIDTH) width_reg = value & 11'h7FF;
        else height_reg = value & 13'h1FFF;
    endtask

    // One full frame plus its drain. Patterns: 0 random, 1 checkerboard,
    // 2 all white, 3 all black. Drain items mix flushes and ignored pixels.
    task automatic send_frame(int fw, int fh, int pattern, int flush_pct);
        logic [23:0] rgb;
        int w, h;
        write_reg(sem_pkg::REG_FRAME_WIDTH, fw);
        write_reg(sem_pkg::REG_FRAME_HEIGHT, fh);
        w = clamp_size(fw & 11'h7FF, MAX_W);
        h = clamp_size(fh & 13'h1FFF, MAX_H);
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                case (pattern)
                    1: rgb = ((x + y) % 2) ? 24'hFFFFFF : 24'h000000;
                    2: rgb = 24'hFFFFFF;
                    3: rgb = 24'h000000;
                    default: rgb = $urandom();
                endcase
                if ($urandom_range(99) < flush_pct) send_item(sem_pkg::CMD_FLUSH, $urandom());
                else send_item(sem_pkg::CMD_PIXEL, rgb);
            end
        end
        for (int k = 0; k <= w; k++)
            send_item($urandom_range(1) ? sem_pkg::CMD_FLUSH : sem_pkg::CMD_PIXEL, $urandom());
        wait_drained();
    endtask

    // Borders, saturation, zero sizes and flushes inside a frame.
    task automatic test_directed();
        send_frame(0, 0, 2, 0);
        send_frame(3, 3, 1, 0);
        send_frame(2, 2, 2, 0);
        send_frame(3, 2, 3, 0);
        send_frame(4, 1, 0, 30);
    endtask

    // Register values wider than the registers keep only their low bits.
    task automatic test_size_limits();
        send_frame(2048, 3, 0, 3);
        send_frame(5, 8194, 1, 0);
        send_frame(6, 0, 0, 3);
    endtask

    // Back-to-back frames without any idling on either side.
    task automatic test_full_rate();
        no_idle = 1'b1;
        for (int i = 0; i < 4; i++)
            send_frame($urandom_range(12, 2), $urandom_range(6, 2), 0, 0);
        no_idle = 1'b0;
    endtask

    // Random frames, mostly small, with occasional flushes mid-frame.
    task automatic test_random_frames();
        int start;
        start = item_count;
        while (item_count - start < 600) begin
            if ($urandom_range(9) == 0)
                send_frame($urandom_range(40, 1), $urandom_range(4, 1),
                           $urandom_range(3), 5);
            else
                send_frame($urandom_range(10, 1), $urandom_range(8, 1),
                           ($urandom_range(4) == 0) ? $urandom_range(3) : 0, 5);
        end
    endtask

    // Output side stalls at random.
    always @(posedge i_clk)
        i_ready <= no_idle || ($urandom_range(99) >= 12);

    // Compare each result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_mag want, got;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_out_red, o_out_green, o_out_blue, o_end_of_frame};
            if (pending_mags.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: rgb %0d %0d %0d eof %0b",
                             got.red, got.green, got.blue, got.eof);
            end else begin
                want = pending_mags.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %0d %0d %0d eof %0b, got %0d %0d %0d eof %0b",
                                 want.red, want.green, want.blue, want.eof,
                                 got.red, got.green, got.blue, got.eof);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        foreach (upper_line[i]) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        foreach (window_pix[i]) window_pix[i] = '0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_rate();
        test_random_frames();
        test_size_limits();

        wait_drained();
        if (mismatch_count == 0 && pending_mags.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
